// File: hdl/vbd_pkg.sv
// Shared types and constants for the vibration burst detector.
// No dependencies; imported by vbd_ctrl, vbd_dp and vibration_burst_detector.
`default_nettype none

package vbd_pkg;

    // Sample width taken from each axis field (8..16)
    localparam int SAMPLE_WIDTH = 16;

    localparam int AXIS_W      = 16;
    localparam int MAG_W       = 16;
    localparam int ROOT_W      = SAMPLE_WIDTH;
    localparam int SUM_W       = 2 * SAMPLE_WIDTH;
    localparam int REM_W       = SAMPLE_WIDTH + 2;
    localparam int CNT_W       = $clog2(SAMPLE_WIDTH);
    localparam int NUM_AXES    = 3;
    localparam int SEL_W       = 2;
    localparam int RUN_W       = 8;
    localparam int THR_W       = 16;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH = 2'd1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET  = 16'd819;
    localparam logic [RUN_W-1:0] RUN_LENGTH_RESET = 8'd5;
    localparam logic [RUN_W-1:0] RUN_MAX          = 8'd255;

    // Square phase: three products plus one trailing add
    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(NUM_AXES);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(SAMPLE_WIDTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic             load;
        logic             sq_mul;
        logic             sq_add;
        logic [SEL_W-1:0] sq_sel;
        logic             root_step;
        logic             decide;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

// File: hdl/vibration_burst_detector.sv
// Top level of the vibration burst detector: stream ports and config port.
// Depends on vbd_pkg, vbd_ctrl and vbd_dp.
`default_nettype none

// One sample in, one result out. A sample is taken when the block is idle;
// it then passes through the shared squarer (one 16x16 multiply per axis
// plus the trailing add), the square root, which resolves one root bit per
// cycle, and the run detector, and no new sample is taken until its decide
// step is done. The result sits in an output register, so the next sample is
// taken while a finished beat waits; a stalled output only holds the block in
// its decide step. Config registers take effect at the next decide step and
// are written with o_cfg_ready always high.
module vibration_burst_detector (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // axis_x [15:0], axis_y [31:16], axis_z [47:32]
    input  wire logic [vbd_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // active [0], started [1], stopped [2], magnitude [18:3], zero [23:19]
    output logic [vbd_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [vbd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [vbd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import vbd_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    vbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    vbd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: hdl/vbd_ctrl.sv
// Sequencer for the vibration burst detector: accept, square, root, decide.
// Depends on vbd_pkg; drives the command struct into vbd_dp.
`default_nettype none

module vbd_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire vbd_pkg::t_status i_status,
    output vbd_pkg::t_cmd        o_cmd
);
    import vbd_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                if (r_cnt == SQ_LAST) begin
                    n_state = S_ROOT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ROOT: begin
                if (r_cnt == ROOT_LAST) begin
                    n_state = S_DECIDE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DECIDE: begin
                if (!i_status.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SQUARE: begin
                // product of axis n is added in the following cycle
                o_cmd.sq_mul = (r_cnt != SQ_LAST);
                o_cmd.sq_add = (r_cnt != '0);
                o_cmd.sq_sel = r_cnt[SEL_W-1:0];
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
            end
            S_DECIDE: begin
                o_cmd.decide = !i_status.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_load_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_in_ready)
        else $error("ready held after a beat was taken");
    a_decide_not_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.decide |-> !i_status.out_busy)
        else $error("result issued over a pending output beat");
    a_decide_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.decide |=> !o_cmd.decide)
        else $error("two results for one sample");
`endif

endmodule

`default_nettype wire

// File: hdl/vbd_dp.sv
// Datapath: axis magnitudes, shared squarer, bit-serial square root,
// run detection and the output register. Depends on vbd_pkg.
`default_nettype none

module vbd_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire vbd_pkg::t_cmd                   i_cmd,
    output vbd_pkg::t_status                     o_status,
    input  wire logic [vbd_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [vbd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [vbd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [vbd_pkg::OUT_TDATA_W-1:0]      o_out_data
);
    import vbd_pkg::*;

    logic [THR_W-1:0]  r_threshold;
    logic [RUN_W-1:0]  r_run_length;

    logic [ROOT_W-1:0] r_abs [NUM_AXES];
    logic [ROOT_W-1:0] n_abs [NUM_AXES];
    logic [SUM_W-1:0]  r_prod;
    logic [SUM_W-1:0]  r_sum;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [MAG_W-1:0]  r_prev_mag;
    logic              r_have_prev;
    logic [RUN_W-1:0]  r_run;
    logic              r_active;

    logic              r_out_valid;
    logic              r_out_active, r_out_started, r_out_stopped;
    logic [MAG_W-1:0]  r_out_mag;

    logic [ROOT_W-1:0] sq_op;
    logic [REM_W-1:0]  rem_sh, trial;
    logic              trial_ok;

    logic [MAG_W-1:0]  mag, diff;
    logic              over;
    logic [RUN_W-1:0]  n_run;
    logic              active_mid, started, stopped;

    // abs of the low SAMPLE_WIDTH bits; the most negative code maps to 2^(W-1)
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            n_abs[k] = i_in_data[k*AXIS_W +: ROOT_W];
            if (n_abs[k][ROOT_W-1]) begin
                n_abs[k] = ~n_abs[k] + 1'b1;
            end
        end
    end

    always_comb begin
        case (i_cmd.sq_sel)
            2'd0:    sq_op = r_abs[0];
            2'd1:    sq_op = r_abs[1];
            2'd2:    sq_op = r_abs[2];
            default: sq_op = '0;
        endcase
    end

    // one root bit per step; remainder stays below 2^W until the last step
    assign rem_sh   = {r_rem[ROOT_W-1:0], r_sum[SUM_W-1 -: 2]};
    assign trial    = {r_root, 2'b01};
    assign trial_ok = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_abs[k] <= n_abs[k];
            end
            r_sum  <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_sum  <= {r_sum[SUM_W-3:0], 2'b00};
            r_rem  <= trial_ok ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], trial_ok};
        end else if (i_cmd.sq_add) begin
            r_sum <= r_sum + r_prod;
        end
        if (i_cmd.sq_mul) begin
            r_prod <= SUM_W'(sq_op) * SUM_W'(sq_op);
        end
    end

    // detection on the finished magnitude
    always_comb begin
        mag = MAG_W'(r_root);
        if (!r_have_prev) begin
            diff = '0;
        end else if (mag >= r_prev_mag) begin
            diff = mag - r_prev_mag;
        end else begin
            diff = r_prev_mag - mag;
        end
        over = (diff > r_threshold);
        if (!over) begin
            n_run = '0;
        end else if (r_run == RUN_MAX) begin
            n_run = r_run;
        end else begin
            n_run = r_run + 1'b1;
        end
        stopped    = !over && r_active;
        active_mid = over && r_active;
        started    = (n_run > r_run_length) && !active_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RESET;
            r_run_length <= RUN_LENGTH_RESET;
            r_prev_mag   <= '0;
            r_have_prev  <= 1'b0;
            r_run        <= '0;
            r_active     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_THRESHOLD:  r_threshold  <= i_cfg_data[THR_W-1:0];
                    REG_RUN_LENGTH: r_run_length <= i_cfg_data[RUN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.decide) begin
                r_prev_mag  <= mag;
                r_have_prev <= 1'b1;
                r_run       <= n_run;
                r_active    <= active_mid || started;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_out_active  <= active_mid || started;
            r_out_started <= started;
            r_out_stopped <= stopped;
            r_out_mag     <= mag;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    // bit 0 active, 1 started, 2 stopped, 18:3 magnitude
    assign o_out_data = {{(OUT_TDATA_W - MAG_W - 3){1'b0}}, r_out_mag,
                         r_out_stopped, r_out_started, r_out_active};

`ifndef ASSERT_OFF
    a_decide_shows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |=> o_out_valid)
        else $error("result not presented after decide");
    a_start_is_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_out_started |-> r_out_active && !r_out_stopped)
        else $error("start flagged without active state");
    a_stop_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide && stopped |=> r_run == '0 && !r_active)
        else $error("stop left run count or active state set");
`endif

endmodule

`default_nettype wire
